FILE: sv/eci_pkg.sv
// Shared types and constants for the easing-curve interpolator.
// Used by every module of the block; depends on nothing.
package eci_pkg;

  localparam int FRAC = 15;
  localparam int PIPE_DEPTH = 9;

  localparam logic [15:0] ONE  = 16'(1 << FRAC);
  localparam logic [15:0] HALF = 16'(1 << (FRAC - 1));

  localparam logic [2:0] FUNC_LINEAR     = 3'd0;
  localparam logic [2:0] FUNC_IN_OUT     = 3'd1;
  localparam logic [2:0] FUNC_OUT_CUBIC  = 3'd2;
  localparam logic [2:0] FUNC_OUT_BACK   = 3'd3;
  localparam logic [2:0] FUNC_OUT_BOUNCE = 3'd4;

  localparam logic [30:0] BACK_C1 = 31'd1827057613;
  localparam logic [31:0] BACK_C3 = 32'd2900799437;

  localparam logic [18:0] BOUNCE_LIM1 = 19'(4 << FRAC);
  localparam logic [18:0] BOUNCE_LIM2 = 19'(8 << FRAC);
  localparam logic [18:0] BOUNCE_LIM3 = 19'(10 << FRAC);
  localparam logic [20:0] BOUNCE_K1   = 21'(12 << FRAC);
  localparam logic [20:0] BOUNCE_K2   = 21'(18 << FRAC);
  localparam logic [20:0] BOUNCE_K3   = 21'(21 << FRAC);
  localparam logic [15:0] BOUNCE_B1   = 16'(3 << (FRAC - 2));
  localparam logic [15:0] BOUNCE_B2   = 16'(15 << (FRAC - 4));
  localparam logic [15:0] BOUNCE_B3   = 16'(63 << (FRAC - 6));

  typedef enum logic [2:0] {
    OP_LINEAR,
    OP_IN_LO,
    OP_IN_HI,
    OP_OUT_CUBIC,
    OP_BACK,
    OP_BOUNCE
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [15:0]        t;
    logic [15:0]        x;
    logic signed [19:0] d;
    logic [15:0]        base;
    logic signed [15:0] a;
    logic signed [16:0] span;
  } prep_t;

  typedef struct packed {
    logic signed [16:0] e;
    logic signed [15:0] a;
    logic signed [16:0] span;
  } ease_t;

endpackage

FILE: sv/eci_prep.sv
// Input stage: clamp progress, pick curve operands and bounce segment.
// Depends on eci_pkg.
module eci_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          func,
  input  logic signed [15:0]  start_value,
  input  logic signed [15:0]  end_value,
  input  logic signed [16:0]  progress,
  output logic                out_valid,
  input  logic                out_ready,
  output eci_pkg::prep_t      out_data
);

  logic               vld;
  logic               ld;
  eci_pkg::prep_t     data_next;
  logic [15:0]        t;
  logic [15:0]        s;
  logic [16:0]        s2;
  logic [18:0]        t11;
  logic [19:0]        t22;
  logic [20:0]        koff;
  logic signed [21:0] dw;

  always_comb begin
    if (progress[16]) begin
      t = '0;
    end else if (progress[15:0] > eci_pkg::ONE) begin
      t = eci_pkg::ONE;
    end else begin
      t = progress[15:0];
    end
    s   = eci_pkg::ONE - t;
    s2  = {s, 1'b0};
    t11 = {3'b000, t} + {2'b00, t, 1'b0} + {t, 3'b000};
    t22 = {t11, 1'b0};

    data_next.op   = eci_pkg::OP_LINEAR;
    data_next.t    = t;
    data_next.x    = t;
    data_next.a    = start_value;
    data_next.span = $signed({end_value[15], end_value}) - $signed({start_value[15], start_value});

    unique case (func)
      eci_pkg::FUNC_IN_OUT: begin
        if (t < eci_pkg::HALF) begin
          data_next.op = eci_pkg::OP_IN_LO;
          data_next.x  = t;
        end else begin
          data_next.op = eci_pkg::OP_IN_HI;
          data_next.x  = s2[15:0];
        end
      end
      eci_pkg::FUNC_OUT_CUBIC: begin
        data_next.op = eci_pkg::OP_OUT_CUBIC;
        data_next.x  = s;
      end
      eci_pkg::FUNC_OUT_BACK: begin
        data_next.op = eci_pkg::OP_BACK;
        data_next.x  = s;
      end
      eci_pkg::FUNC_OUT_BOUNCE: begin
        data_next.op = eci_pkg::OP_BOUNCE;
      end
      default: begin
        data_next.op = eci_pkg::OP_LINEAR;
      end
    endcase

    priority if (t11 < eci_pkg::BOUNCE_LIM1) begin
      koff           = '0;
      data_next.base = '0;
    end else if (t11 < eci_pkg::BOUNCE_LIM2) begin
      koff           = eci_pkg::BOUNCE_K1;
      data_next.base = eci_pkg::BOUNCE_B1;
    end else if (t11 < eci_pkg::BOUNCE_LIM3) begin
      koff           = eci_pkg::BOUNCE_K2;
      data_next.base = eci_pkg::BOUNCE_B2;
    end else begin
      koff           = eci_pkg::BOUNCE_K3;
      data_next.base = eci_pkg::BOUNCE_B3;
    end
    dw          = $signed({2'b00, t22}) - $signed({1'b0, koff});
    data_next.d = dw[19:0];
  end

  assign ld        = !vld || out_ready;
  assign in_ready  = ld;
  assign out_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ld) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data <= data_next;
    end
  end

endmodule

FILE: sv/eci_curve.sv
// Easing curve evaluation: six register stages of squares, cubes,
// back-curve products and bounce parabola. Depends on eci_pkg.
module eci_curve (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  eci_pkg::prep_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output eci_pkg::ease_t out_data
);

  localparam int NS = 6;

  logic [NS-1:0] vld;
  logic [NS-1:0] ld;

  eci_pkg::op_t       op1, op2, op3, op4, op5;
  logic [15:0]        t1, t2, t3;
  logic [15:0]        x1, x2;
  logic [15:0]        base1;
  logic signed [15:0] a1, a2, a3, a4, a5;
  logic signed [16:0] span1, span2, span3, span4, span5;
  logic [30:0]        p1;
  logic signed [39:0] pd1;
  logic [15:0]        sq2;
  logic [16:0]        eb2, eb3;
  logic [30:0]        p2;
  logic [46:0]        bq3, bq4, bq5;
  logic [15:0]        c4;
  logic signed [16:0] epre4, epre5;
  logic [47:0]        bc5;

  logic [31:0]        p1w;
  logic signed [39:0] pdw;
  logic [31:0]        sq_sum;
  logic [39:0]        rb_sum;
  logic [31:0]        p2w;
  logic [46:0]        bqw;
  logic [31:0]        sum13;
  logic [31:0]        sum15;
  logic [31:0]        sum16;
  logic signed [16:0] epre_next;
  logic [47:0]        bcw;
  logic signed [48:0] diff;
  logic [16:0]        eback;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign p1w = in_data.x * in_data.x;
  assign pdw = in_data.d * in_data.d;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      op1   <= in_data.op;
      t1    <= in_data.t;
      x1    <= in_data.x;
      base1 <= in_data.base;
      a1    <= in_data.a;
      span1 <= in_data.span;
      p1    <= p1w[30:0];
      pd1   <= pdw;
    end
  end

  assign sq_sum = {1'b0, p1} + (32'd1 << (eci_pkg::FRAC - 1));
  assign rb_sum = pd1 + (40'd1 << (eci_pkg::FRAC + 5));

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      op2   <= op1;
      t2    <= t1;
      x2    <= x1;
      a2    <= a1;
      span2 <= span1;
      sq2   <= sq_sum[30:15];
      eb2   <= {1'b0, base1} + {1'b0, rb_sum[36:21]};
    end
  end

  assign p2w = sq2 * x2;
  assign bqw = eci_pkg::BACK_C1 * sq2;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      op3   <= op2;
      t3    <= t2;
      a3    <= a2;
      span3 <= span2;
      eb3   <= eb2;
      p2    <= p2w[30:0];
      bq3   <= bqw;
    end
  end

  assign sum13 = {1'b0, p2} + (32'd1 << (eci_pkg::FRAC - 3));
  assign sum15 = {1'b0, p2} + (32'd1 << (eci_pkg::FRAC - 1));
  assign sum16 = {1'b0, p2} + (32'd1 << eci_pkg::FRAC);

  always_comb begin
    unique case (op3)
      eci_pkg::OP_IN_LO:     epre_next = $signed(sum13[29:13]);
      eci_pkg::OP_IN_HI:     epre_next = $signed({1'b0, eci_pkg::ONE} - {2'b00, sum16[30:16]});
      eci_pkg::OP_OUT_CUBIC: epre_next = $signed({1'b0, eci_pkg::ONE} - {1'b0, sum15[30:15]});
      eci_pkg::OP_BOUNCE:    epre_next = $signed(eb3);
      eci_pkg::OP_BACK:      epre_next = '0;
      default:               epre_next = $signed({1'b0, t3});
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      op4   <= op3;
      a4    <= a3;
      span4 <= span3;
      bq4   <= bq3;
      c4    <= sum15[30:15];
      epre4 <= epre_next;
    end
  end

  assign bcw = eci_pkg::BACK_C3 * c4;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      op5   <= op4;
      a5    <= a4;
      span5 <= span4;
      bq5   <= bq4;
      epre5 <= epre4;
      bc5   <= bcw;
    end
  end

  assign diff  = $signed({2'b00, bq5}) - $signed({1'b0, bc5}) + (49'sd1 <<< 29);
  assign eback = {1'b0, eci_pkg::ONE} + diff[46:30];

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      out_data.a    <= a5;
      out_data.span <= span5;
      out_data.e    <= (op5 == eci_pkg::OP_BACK) ? $signed(eback) : epre5;
    end
  end

endmodule

FILE: sv/eci_map.sv
// Interpolation stages: span times eased fraction, round, add start.
// Depends on eci_pkg.
module eci_map (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  eci_pkg::ease_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] eased_fraction,
  output logic signed [17:0] mapped_value
);

  localparam int NS = 2;

  logic [NS-1:0]      vld;
  logic [NS-1:0]      ld;
  logic signed [33:0] prodw;
  logic signed [33:0] prod;
  logic signed [16:0] e1;
  logic signed [15:0] a1;
  logic signed [34:0] rsum;
  logic signed [19:0] vw;

  always_comb begin
    ld[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !vld[i] || ld[i+1];
    end
  end

  assign in_ready  = ld[0];
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign prodw = $signed(in_data.span) * $signed(in_data.e);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      prod <= prodw;
      e1   <= in_data.e;
      a1   <= in_data.a;
    end
  end

  assign rsum = $signed({prod[33], prod}) + (35'sd1 <<< (eci_pkg::FRAC - 1));
  assign vw   = $signed({{4{a1[15]}}, a1}) + rsum[34:15];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      eased_fraction <= e1;
      mapped_value   <= vw[17:0];
    end
  end

endmodule

FILE: sv/easing_curve_interpolator_top.sv
// Throughput: one transaction per cycle while m_tready is high; the
// flow runs through nine elastic register stages (operand prep, curve evaluation, interpolation).
// Reset (synchronous, active high) clears every stage valid bit.
// Depends on eci_pkg, eci_prep, eci_curve, eci_map.
module easing_curve_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // start_value[15:0], end_value[31:16], progress[48:32], zero pad
  input  logic [2:0]  s_tuser,   // func[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // eased_fraction[16:0], mapped_value[34:17], zero pad
);

  logic               prep_valid;
  logic               prep_ready;
  eci_pkg::prep_t     prep_data;
  logic               ease_valid;
  logic               ease_ready;
  eci_pkg::ease_t     ease_data;
  logic signed [16:0] eased_fraction;
  logic signed [17:0] mapped_value;

  eci_prep u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .start_value ($signed(s_tdata[15:0])),
    .end_value   ($signed(s_tdata[31:16])),
    .progress    ($signed(s_tdata[48:32])),
    .out_valid   (prep_valid),
    .out_ready   (prep_ready),
    .out_data    (prep_data)
  );

  eci_curve u_curve (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (ease_valid),
    .out_ready (ease_ready),
    .out_data  (ease_data)
  );

  eci_map u_map (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (ease_valid),
    .in_ready       (ease_ready),
    .in_data        (ease_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .eased_fraction (eased_fraction),
    .mapped_value   (mapped_value)
  );

  assign m_tdata = {5'b00000, mapped_value, eased_fraction};

endmodule

FILE: sv/eci_checker.sv
// Port-level assertions for the easing-curve interpolator, with its bind.
// Depends on eci_pkg and easing_curve_interpolator_top.
module eci_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  logic [4:0] pending;
  logic [4:0] pending_next;

  always_comb begin
    pending_next = pending;
    if (s_tvalid && s_tready) begin
      pending_next = pending_next + 5'd1;
    end
    if (m_tvalid && m_tready) begin
      pending_next = pending_next - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending_next;
    end
  end

  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 5'd0)
    else $error("result without an accepted transaction");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 5'(eci_pkg::PIPE_DEPTH))
    else $error("more transactions in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input blocked while output is free");

endmodule

bind easing_curve_interpolator_top eci_checker u_eci_checker (.*);
